// ===== rtl/core/cbsp_pkg.sv =====
`default_nettype none

package cbsp_pkg;

    localparam int SUBHEADER_BYTES   = 20;
    localparam int MAX_ENCODE_LENGTH = 512;

    localparam int DATA_W   = 8;
    localparam int SIZE_W   = 24;
    localparam int ENC_W    = 10;
    localparam int BLOCK_W  = 16;
    localparam int CODE_W   = 4;
    localparam int WIDTH_W  = 5;
    localparam int SKIP_W   = 11;
    localparam int OFFS_W   = SIZE_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam int NUM_CODES = 11;
    localparam int MAX_WIDTH = 16;

    localparam logic [CODE_W-1:0]  BAD_CODE  = 4'd15;
    localparam logic [BLOCK_W-1:0] BLOCK_MAX = {BLOCK_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGINAL_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_LENGTH = 1'd1;

    localparam logic [SIZE_W-1:0] ORIG_SIZE_RESET   = '0;
    localparam logic [ENC_W-1:0]  ENCODE_LEN_RESET  = 10'd256;

    typedef enum logic [1:0] {
        ST_RUNNING    = 2'd0,
        ST_COVERED    = 2'd1,
        ST_BAD_HEADER = 2'd2,
        ST_TOTAL      = 2'd3
    } t_status;

    typedef struct packed {
        logic                 is_header;
        logic [BLOCK_W-1:0]   block_index;
        logic                 done_res;
        t_status              status;
        logic [SIZE_W-1:0]    compressed_length;
    } t_result;

    // half the token byte count for each block code
    function automatic logic [2:0] half_tokens(input logic [CODE_W-1:0] code);
        logic [2:0] k;
        unique case (code)
            4'd0:    k = 3'd0;
            4'd1:    k = 3'd1;
            4'd2:    k = 3'd1;
            4'd3:    k = 3'd2;
            4'd4:    k = 3'd3;
            4'd5:    k = 3'd4;
            4'd6:    k = 3'd3;
            4'd7:    k = 3'd3;
            4'd8:    k = 3'd4;
            4'd9:    k = 3'd4;
            4'd10:   k = 3'd4;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/compressed_block_stream_parser.sv =====
// channel  | handshake                     | payload
// ---------+-------------------------------+------------------------------------------
// input    | i_valid / o_stall             | i_data_byte
// result   | o_valid / i_stall             | o_is_header, o_block_index, o_done_res,
//          |                               | o_status, o_compressed_length
// config   | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// one byte per cycle while o_stall is low; the parse state updates in the cycle a byte is
// taken and the result is registered in the output register, or in the skid entry while the result side stalls
// the longest path is the block-count times encode-length multiply and compare
// a two-entry output buffer takes one more byte while the result side stalls, then raises o_stall
// reset is synchronous active low and returns the parse state, config and valid flags to defaults
`default_nettype none

module compressed_block_stream_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [cbsp_pkg::DATA_W-1:0]     i_data_byte,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_is_header,
    output logic [cbsp_pkg::BLOCK_W-1:0]         o_block_index,
    output logic                                 o_done_res,
    output logic [1:0]                           o_status,
    output logic [cbsp_pkg::SIZE_W-1:0]          o_compressed_length,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cbsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cbsp_pkg::SIZE_W-1:0]     i_cfg_data
);
    import cbsp_pkg::*;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_WIDTH = 2'd1,
        PH_SKIP  = 2'd2
    } t_phase;

    localparam int PROD_W = BLOCK_W + ENC_W;
    localparam int MULW_W = WIDTH_W + ENC_W;
    localparam int SUM_W  = OFFS_W + 1;

    localparam logic [SIZE_W-1:0] SUB_BYTES = SIZE_W'(SUBHEADER_BYTES);
    localparam logic [ENC_W:0]    MAX_ENC   = (ENC_W + 1)'(MAX_ENCODE_LENGTH);

    // config
    logic [SIZE_W-1:0]  r_orig_size;
    logic [ENC_W-1:0]   r_enc_len;

    // parse state
    t_phase              r_phase,        n_phase;
    logic [CODE_W-1:0]   r_held_code,    n_held_code;
    logic [SKIP_W-1:0]   r_skip_left,    n_skip_left;
    logic [BLOCK_W-1:0]  r_blocks,       n_blocks;
    logic [SIZE_W-1:0]   r_bytes_seen,   n_bytes_seen;
    logic [OFFS_W-1:0]   r_block_end,    n_block_end;
    logic                r_stopped,      n_stopped;
    t_status             r_final_status, n_final_status;

    // output buffer
    logic     r_out_valid;
    logic     r_skid_valid;
    t_result  r_out;
    t_result  r_skid;
    t_result  n_result;

    logic               in_acc;
    logic               out_take;
    logic               cfg_acc;
    logic [ENC_W-1:0]   eff_len;
    logic [SIZE_W-1:0]  byte_total;
    logic [PROD_W-1:0]  done_samples;
    logic               covered;
    logic [2:0]         tok_half;
    logic [ENC_W-1:0]   packed_cnt;
    logic [MULW_W-1:0]  packed_bits;
    logic [MULW_W-1:0]  packed_bytes;
    logic [SKIP_W-1:0]  cnt_raw;
    logic [SKIP_W-1:0]  cnt_even;
    logic               hdr;
    logic [OFFS_W-1:0]  len_src;
    logic [SUM_W-1:0]   len_sum;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_stall     = r_skid_valid;
    assign in_acc      = i_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_stall;

    assign eff_len    = ({1'b0, r_enc_len} > MAX_ENC) ? MAX_ENC[ENC_W-1:0] : r_enc_len;
    assign byte_total = (r_orig_size > SUB_BYTES) ? (r_orig_size - SUB_BYTES) : '0;

    // coverage test at a block start
    assign done_samples = PROD_W'(r_blocks - BLOCK_W'(1)) * PROD_W'(eff_len);
    assign covered      = (r_blocks != '0)
                       && (done_samples >= PROD_W'(r_orig_size >> 1));

    // block body length from code and bit width
    assign tok_half     = half_tokens(r_held_code);
    assign packed_cnt   = (eff_len > ENC_W'(tok_half)) ? (eff_len - ENC_W'(tok_half)) : '0;
    assign packed_bits  = MULW_W'(i_data_byte[WIDTH_W-1:0]) * MULW_W'(packed_cnt);
    assign packed_bytes = (packed_bits + MULW_W'(7)) >> 3;
    assign cnt_raw      = SKIP_W'({tok_half, 1'b0}) + SKIP_W'(packed_bytes);
    assign cnt_even     = cnt_raw + SKIP_W'(cnt_raw[0]);

    always_comb begin
        n_phase        = r_phase;
        n_held_code    = r_held_code;
        n_skip_left    = r_skip_left;
        n_blocks       = r_blocks;
        n_bytes_seen   = r_bytes_seen;
        n_block_end    = r_block_end;
        n_stopped      = r_stopped;
        n_final_status = r_final_status;
        hdr            = 1'b0;

        if (!r_stopped) begin
            if (r_bytes_seen >= byte_total) begin
                n_stopped      = 1'b1;
                n_final_status = ST_TOTAL;
            end else begin
                n_bytes_seen = r_bytes_seen + SIZE_W'(1);
                unique case (r_phase)
                    PH_CODE: begin
                        if (covered) begin
                            n_stopped      = 1'b1;
                            n_final_status = ST_COVERED;
                        end else begin
                            n_held_code = (i_data_byte >= DATA_W'(NUM_CODES))
                                        ? BAD_CODE : i_data_byte[CODE_W-1:0];
                            n_phase     = PH_WIDTH;
                            hdr         = 1'b1;
                        end
                    end
                    PH_WIDTH: begin
                        hdr = 1'b1;
                        if (r_held_code >= CODE_W'(NUM_CODES)
                                || i_data_byte > DATA_W'(MAX_WIDTH)) begin
                            n_stopped      = 1'b1;
                            n_final_status = ST_BAD_HEADER;
                        end else begin
                            n_block_end = r_block_end + OFFS_W'(cnt_even) + OFFS_W'(2);
                            if (r_blocks != BLOCK_MAX) begin
                                n_blocks = r_blocks + BLOCK_W'(1);
                            end
                            n_skip_left = cnt_even;
                            n_phase     = (cnt_even != '0) ? PH_SKIP : PH_CODE;
                        end
                    end
                    PH_SKIP: begin
                        if (r_skip_left != '0) begin
                            n_skip_left = r_skip_left - SKIP_W'(1);
                        end
                        if (n_skip_left == '0) begin
                            n_phase = PH_CODE;
                        end
                    end
                    default: begin
                        n_phase = PH_CODE;
                    end
                endcase
                if (!n_stopped && n_bytes_seen >= byte_total) begin
                    n_stopped      = 1'b1;
                    n_final_status = ST_TOTAL;
                end
            end
        end
    end

    // length reported: whole blocks once coverage stops, bytes received otherwise
    // a coverage stop never moves the block end, so the register value serves
    assign len_src = (n_stopped && n_final_status == ST_COVERED)
                   ? r_block_end : OFFS_W'(n_bytes_seen);
    assign len_sum = SUM_W'(len_src) + SUM_W'(SUBHEADER_BYTES);

    always_comb begin
        n_result.is_header         = hdr;
        n_result.block_index       = n_blocks;
        n_result.done_res          = n_stopped;
        n_result.status            = n_stopped ? n_final_status : ST_RUNNING;
        n_result.compressed_length = (len_sum > SUM_W'(r_orig_size))
                                   ? r_orig_size : len_sum[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orig_size    <= ORIG_SIZE_RESET;
            r_enc_len      <= ENCODE_LEN_RESET;
            r_phase        <= PH_CODE;
            r_held_code    <= '0;
            r_skip_left    <= '0;
            r_blocks       <= '0;
            r_bytes_seen   <= '0;
            r_block_end    <= '0;
            r_stopped      <= 1'b0;
            r_final_status <= ST_RUNNING;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_ORIGINAL_SIZE: r_orig_size <= i_cfg_data;
                    CFG_ENCODE_LENGTH: r_enc_len   <= i_cfg_data[ENC_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_phase        <= n_phase;
                r_held_code    <= n_held_code;
                r_skip_left    <= n_skip_left;
                r_blocks       <= n_blocks;
                r_bytes_seen   <= n_bytes_seen;
                r_block_end    <= n_block_end;
                r_stopped      <= n_stopped;
                r_final_status <= n_final_status;
            end
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_is_header         = r_out.is_header;
    assign o_block_index       = r_out.block_index;
    assign o_done_res          = r_out.done_res;
    assign o_status            = r_out.status;
    assign o_compressed_length = r_out.compressed_length;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("parser left the stopped state");

    a_stop_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_final_status != ST_RUNNING))
        else $error("stopped without a status");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip_left != '0))
        else $error("body skip phase with nothing left to skip");

    a_done_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_done_res == (o_status != ST_RUNNING)))
        else $error("done flag and status disagree");

endmodule

`default_nettype wire
